>>> rtl/core/hff_pkg.sv
// Shared types, widths and command codes of the HMM forward filter.
`default_nettype none
package hff_pkg;
    localparam int NUM_STATES  = 8;
    localparam int NUM_SYMBOLS = 16;

    localparam int PROB_W = 17;
    localparam int ST_W   = $clog2(NUM_STATES);
    localparam int TA_W   = $clog2(NUM_STATES * NUM_STATES);
    localparam int EA_W   = $clog2(NUM_STATES * NUM_SYMBOLS);
    // sum of NUM_STATES products, each up to 2^32
    localparam int ACC_W  = 33 + ST_W;
    localparam int LO_W   = 18;
    localparam int HI_W   = ACC_W - LO_W;
    localparam int C_W    = ACC_W + ST_W;
    localparam int LIK_W  = 33;

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(65536);
    localparam logic [LIK_W-1:0]  LIK_ONE  = {1'b1, 32'd0};

    typedef enum logic [2:0] {
        CMD_LOAD_TRANS = 3'd0,
        CMD_LOAD_EMIS  = 3'd1,
        CMD_LOAD_INIT  = 3'd2,
        CMD_OBSERVE    = 3'd3,
        CMD_RESTART    = 3'd4
    } cmd_t;
endpackage
`default_nettype wire

>>> rtl/core/hff_cell.sv
// One cell of the filter chain: holds one filter value and one unnormalized z.
`default_nettype none
module hff_cell (
    input  wire logic                        aclk,
    input  wire logic                        f_clr,
    input  wire logic                        f_shift,
    input  wire logic [hff_pkg::PROB_W-1:0]  f_in,
    output logic      [hff_pkg::PROB_W-1:0]  f_out,
    input  wire logic                        z_shift,
    input  wire logic [hff_pkg::ACC_W-1:0]   z_in,
    output logic      [hff_pkg::ACC_W-1:0]   z_out
);
    import hff_pkg::*;

    logic [PROB_W-1:0] f_reg;
    logic [ACC_W-1:0]  z_reg;

    // filter value: cleared on restart, shifted toward the head; z value shifted on z_shift
    always_ff @(posedge aclk) begin
        if (f_clr) begin
            f_reg <= '0;
        end else if (f_shift) begin
            f_reg <= f_in;
        end
        if (z_shift) begin
            z_reg <= z_in;
        end
    end

    assign f_out = f_reg;
    assign z_out = z_reg;
endmodule
`default_nettype wire

>>> rtl/core/hmm_forward_filter_top.sv
// Top level of the scaled HMM forward filter: sequencer, tables, MAC and divider.
//
// Input requests arrive on s_tvalid/s_tready; s_tuser carries the command,
// s_tdata the row, column, probability and symbol. Load and restart requests
// give no result. An observe request with a valid symbol gives NUM_STATES
// results on m_tvalid/m_tready, one per state in state order, m_tlast on the
// final one and m_tuser set when the step likelihood was zero.
// For an observe, per state the sequencer runs one multiply-accumulate a
// cycle over the filter chain (rotating past the shared 17x17 multiplier),
// a pipeline drain, two partial products for the emission scale and a sum
// step. Then per state it runs a load step, a restoring divide for the
// 17-bit quotient on one shared divider and an output step. The first
// symbol after a restart skips the accumulate.
// s_tready is high only while idle; a stalled receiver holds the result in
// the output register and stops the sequencer until it is taken.
// Reset (aresetn low, synchronous) returns to idle with a new sequence
// pending; the tables stay unknown until they are loaded.
`default_nettype none
module hmm_forward_filter_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] row_index, [6:3] col_index, [23:7] prob_value, [27:24] symbol
    input  wire logic [31:0] s_tdata,
    // [2:0] command
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [2:0] state_index, [19:3] filtered_prob, [52:20] step_likelihood
    output logic [55:0]      m_tdata,
    // [0] zero_likelihood
    output logic [0:0]       m_tuser,
    output logic             m_tlast
);
    import hff_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_DRAIN, S_MLO, S_MHI, S_ZSUM, S_DLOAD, S_DIV, S_OUT
    } state_t;

    // request decode
    logic [2:0]        in_cmd;
    logic [2:0]        in_row;
    logic [3:0]        in_col;
    logic [PROB_W-1:0] in_prob_raw;
    logic [PROB_W-1:0] in_prob;
    logic [3:0]        in_sym;
    logic              in_acc;

    assign in_cmd      = s_tuser;
    assign in_row      = s_tdata[2:0];
    assign in_col      = s_tdata[6:3];
    assign in_prob_raw = s_tdata[23:7];
    assign in_sym      = s_tdata[27:24];
    assign in_prob     = (in_prob_raw > PROB_ONE) ? PROB_ONE : in_prob_raw;
    assign in_acc      = s_tvalid && s_tready;

    logic row_ok, col_st_ok, col_sym_ok, sym_ok;
    assign row_ok     = {6'd0, in_row} < 9'(NUM_STATES);
    assign col_st_ok  = {5'd0, in_col} < 9'(NUM_STATES);
    assign col_sym_ok = {5'd0, in_col} < 9'(NUM_SYMBOLS);
    assign sym_ok     = {5'd0, in_sym} < 9'(NUM_SYMBOLS);

    state_t             state_reg;
    logic [ST_W-1:0]    i_reg, j_reg;
    logic [3:0]         sym_reg;
    logic               first_reg;
    logic               v1_reg, v2_reg;
    logic [33:0]        prod_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [LO_W+PROB_W-1:0] plo_reg;
    logic [HI_W+PROB_W-1:0] phi_reg;
    logic [C_W-1:0]     c_reg;
    logic               zero_reg;
    logic [C_W:0]       rem_reg;
    logic [PROB_W-1:0]  q_reg;
    logic [4:0]         dcnt_reg;
    logic               m_valid_reg;
    logic [55:0]        m_data_reg;
    logic               m_zero_reg;
    logic               m_last_reg;

    // tables
    logic [PROB_W-1:0] trans_mem [NUM_STATES*NUM_STATES];
    logic [PROB_W-1:0] emis_mem  [NUM_STATES*NUM_SYMBOLS];
    logic [PROB_W-1:0] init_reg  [NUM_STATES];
    logic [PROB_W-1:0] trans_q, emis_q;
    logic [TA_W-1:0]   ta_wr, ta_rd;
    logic [EA_W-1:0]   ea_wr, ea_rd;

    assign ta_wr = TA_W'(in_row * NUM_STATES + in_col);
    assign ea_wr = EA_W'(in_row * NUM_SYMBOLS + in_col);
    assign ta_rd = TA_W'(i_reg * NUM_STATES + j_reg);
    assign ea_rd = EA_W'(j_reg * NUM_SYMBOLS + sym_reg);

    always_ff @(posedge aclk) begin
        if (in_acc && in_cmd == CMD_LOAD_TRANS && row_ok && col_st_ok) begin
            trans_mem[ta_wr] <= in_prob;
        end
        if (in_acc && in_cmd == CMD_LOAD_EMIS && row_ok && col_sym_ok) begin
            emis_mem[ea_wr] <= in_prob;
        end
        if (in_acc && in_cmd == CMD_LOAD_INIT && row_ok) begin
            init_reg[in_row[ST_W-1:0]] <= in_prob;
        end
        trans_q <= trans_mem[ta_rd];
        emis_q  <= emis_mem[ea_rd];
    end

    // cell chain
    logic [PROB_W-1:0] f_link [NUM_STATES+1];
    logic [ACC_W-1:0]  z_link [NUM_STATES+1];
    logic              f_clr, f_shift, z_shift;
    logic [PROB_W-1:0] f_new;
    logic [ACC_W-1:0]  z_new;

    genvar k;
    generate
        for (k = 0; k < NUM_STATES; k++) begin : g_cell
            hff_cell u_cell (
                .aclk   (aclk),
                .f_clr  (f_clr),
                .f_shift(f_shift),
                .f_in   (f_link[k+1]),
                .f_out  (f_link[k]),
                .z_shift(z_shift),
                .z_in   (z_link[k+1]),
                .z_out  (z_link[k])
            );
        end
    endgenerate

    // tail input: rotate head during accumulate, new value otherwise
    assign f_link[NUM_STATES] = v1_reg ? f_link[0] : f_new;
    assign z_link[NUM_STATES] = z_new;

    // datapath helpers
    logic [ACC_W+PROB_W:0]  zfull;
    logic [C_W-1:0]         c_next;
    logic [C_W:0]           trial;
    logic [C_W:0]           rem_next;
    logic [PROB_W-1:0]      q_next;
    logic [LIK_W-1:0]       lik;

    assign zfull  = (ACC_W+PROB_W+1)'(plo_reg)
                  + ((ACC_W+PROB_W+1)'(phi_reg) << LO_W);
    assign z_new  = zfull[ACC_W+15:16];
    assign c_next = c_reg + C_W'(z_new);
    assign trial  = (dcnt_reg == 5'd0) ? rem_reg : (rem_reg << 1);
    assign rem_next = (trial >= {1'b0, c_reg}) ? (trial - {1'b0, c_reg}) : trial;
    assign q_next = {q_reg[PROB_W-2:0], trial >= {1'b0, c_reg}};
    assign f_new  = zero_reg ? '0 : q_next;
    assign lik    = (c_reg > C_W'(LIK_ONE)) ? LIK_ONE : LIK_W'(c_reg);

    assign f_clr   = in_acc && in_cmd == CMD_RESTART;
    assign f_shift = v1_reg || (state_reg == S_DIV && dcnt_reg == 5'd16);
    assign z_shift = (state_reg == S_ZSUM) || (state_reg == S_DLOAD);

    // sequencer and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            first_reg   <= 1'b1;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
        end else begin
            // accumulate pipeline: product, then add
            v1_reg <= (state_reg == S_MAC) && !first_reg;
            v2_reg <= v1_reg;
            if (v1_reg) begin
                prod_reg <= f_link[0] * trans_q;
            end
            if (v2_reg) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        if (in_cmd == CMD_RESTART) begin
                            first_reg <= 1'b1;
                        end else if (in_cmd == CMD_OBSERVE && sym_ok) begin
                            sym_reg   <= in_sym;
                            i_reg     <= '0;
                            j_reg     <= '0;
                            acc_reg   <= '0;
                            c_reg     <= '0;
                            state_reg <= S_MAC;
                        end
                    end
                end
                S_MAC: begin
                    if (first_reg) begin
                        acc_reg   <= ACC_W'(init_reg[j_reg]) << 16;
                        state_reg <= S_DRAIN;
                    end else if (i_reg == ST_W'(NUM_STATES - 1)) begin
                        i_reg     <= '0;
                        state_reg <= S_DRAIN;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!v1_reg && !v2_reg) begin
                        state_reg <= S_MLO;
                    end
                end
                S_MLO: begin
                    plo_reg   <= acc_reg[LO_W-1:0] * emis_q;
                    state_reg <= S_MHI;
                end
                S_MHI: begin
                    phi_reg   <= acc_reg[ACC_W-1:LO_W] * emis_q;
                    state_reg <= S_ZSUM;
                end
                S_ZSUM: begin
                    c_reg   <= c_next;
                    acc_reg <= '0;
                    if (j_reg == ST_W'(NUM_STATES - 1)) begin
                        j_reg     <= '0;
                        first_reg <= 1'b0;
                        zero_reg  <= (c_next == '0);
                        state_reg <= S_DLOAD;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_MAC;
                    end
                end
                S_DLOAD: begin
                    rem_reg   <= {1'b0, C_W'(z_link[0])};
                    q_reg     <= '0;
                    dcnt_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    rem_reg  <= rem_next;
                    q_reg    <= q_next;
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 5'd16) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {3'd0,
                                        zero_reg ? {LIK_W{1'b0}} : lik,
                                        f_new,
                                        3'(j_reg)};
                        m_zero_reg  <= zero_reg;
                        m_last_reg  <= (j_reg == ST_W'(NUM_STATES - 1));
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        m_valid_reg <= 1'b0;
                        if (j_reg == ST_W'(NUM_STATES - 1)) begin
                            j_reg     <= '0;
                            state_reg <= S_IDLE;
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_DLOAD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // no request is taken while reset is held
    assign s_tready   = (state_reg == S_IDLE) && aresetn;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_zero_reg;
    assign m_tlast    = m_last_reg;
endmodule
`default_nettype wire
